// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register indexes and stage types of the Sobel edge
// magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int LUMA_W            = 8;
   localparam int POS_W             = 12;
   localparam int CFG_W             = 13;
   localparam int GRAD_W            = 11;
   localparam int SQ_W              = 20;
   localparam int RAD_W             = 16;
   localparam int ROOT_W            = 8;
   localparam int CSR_ADDR_W        = 1;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int MAX_HEIGHT        = 4096;
   localparam int MIN_DIM           = 3;
   localparam int RESET_WIDTH       = 640;
   localparam int RESET_HEIGHT      = 480;

   localparam logic [ROOT_W-1:0] SAT_LIMIT = 8'd255;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             done;
   } pos_meta_type;

   typedef struct packed {
      logic                     valid;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      pos_meta_type             meta;
   } grad_item_type;

   typedef struct packed {
      logic             valid;
      logic             sat;
      logic [RAD_W-1:0] radicand;
      pos_meta_type     meta;
   } root_in_type;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [ROOT_W-1:0] root;
      pos_meta_type      meta;
   } root_out_type;

endpackage

// ===== hdl/sem_window_stage.sv =====
// ----------------------------------------------------------------------------
// sem_window_stage
// Raster position counters, two-row line store RAM with write forwarding,
// 3x3 window and the Sobel X/Y gradient of each interior window.
// ----------------------------------------------------------------------------
module sem_window_stage #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [sem_pkg::LUMA_W-1:0]   luma,
   input  logic                         frame_start,
   input  logic [$clog2(MAX_WIDTH):0]   frame_width,
   input  logic [sem_pkg::CFG_W-1:0]    frame_height,
   output sem_pkg::grad_item_type       grad
);
   import sem_pkg::*;

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int EntW = 2 * LUMA_W;
   localparam int SumW = LUMA_W + 2;

   logic                accept;
   logic [ColW-1:0]     col_ff, col_in, col_cur;
   logic [POS_W-1:0]    row_ff, row_in, row_cur;
   logic [ColW:0]       col_inc;
   logic [CFG_W-1:0]    row_inc;
   logic                produce;
   pos_meta_type        meta_cur;

   logic [EntW-1:0]     line_mem [MAX_WIDTH];
   logic [EntW-1:0]     rd_data_ff;
   logic                fwd_hit_ff;
   logic [EntW-1:0]     fwd_data_ff;

   logic                s1_valid_ff;
   logic                s1_produce_ff;
   pos_meta_type        s1_meta_ff;
   logic [LUMA_W-1:0]   s1_luma_ff;
   logic [ColW-1:0]     s1_addr_ff;

   logic [EntW-1:0]     entry;
   logic [LUMA_W-1:0]   px_top, px_mid;
   logic [EntW-1:0]     write_data;
   logic [LUMA_W-1:0]   win_ff [6];

   logic [SumW-1:0]     right_sum, left_sum, bottom_sum, top_sum;
   logic signed [GRAD_W-1:0] gx_c, gy_c;
   grad_item_type       grad_ff;

   assign accept = advance & in_valid;

   // position of the incoming pixel, with restart and wrap
   always_comb begin
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      if ({1'b0, col_cur} >= frame_width) begin
         col_cur = '0;
      end
      if ({1'b0, row_cur} >= frame_height) begin
         row_cur = '0;
      end
      col_inc = {1'b0, col_cur} + (ColW+1)'(1);
      row_inc = {1'b0, row_cur} + CFG_W'(1);
      col_in  = col_inc[ColW-1:0];
      row_in  = row_cur;
      if (col_inc >= frame_width) begin
         col_in = '0;
         row_in = (row_inc >= frame_height) ? '0 : row_inc[POS_W-1:0];
      end
      produce       = (row_cur >= POS_W'(2)) && (col_cur >= ColW'(2));
      meta_cur.row  = row_cur - POS_W'(1);
      meta_cur.col  = POS_W'(col_cur - ColW'(1));
      meta_cur.done = ({1'b0, row_cur} == frame_height - CFG_W'(1))
                      && ({1'b0, col_cur} == frame_width - (ColW+1)'(1));
   end

   // line store entry: upper byte two rows up, lower byte one row up
   always_comb begin
      entry      = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      px_top     = entry[EntW-1:LUMA_W];
      px_mid     = entry[LUMA_W-1:0];
      write_data = {px_mid, s1_luma_ff};
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         line_mem[s1_addr_ff] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[col_cur];
      end
   end

   always_comb begin
      right_sum  = {2'b00, px_top} + {1'b0, px_mid, 1'b0} + {2'b00, s1_luma_ff};
      left_sum   = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
      bottom_sum = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, s1_luma_ff};
      top_sum    = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, px_top};
      gx_c       = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
      gy_c       = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         grad_ff.valid <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         s1_valid_ff   <= in_valid;
         grad_ff.valid <= s1_valid_ff & s1_produce_ff;
         grad_ff.gx    <= gx_c;
         grad_ff.gy    <= gy_c;
         grad_ff.meta  <= s1_meta_ff;
         if (in_valid) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            // same entry written by the pixel ahead in this cycle
            fwd_hit_ff <= s1_valid_ff && (s1_addr_ff == col_cur);
         end
         if (s1_valid_ff) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= px_top;
            win_ff[4] <= px_mid;
            win_ff[5] <= s1_luma_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         if (in_valid) begin
            s1_produce_ff <= produce;
            s1_meta_ff    <= meta_cur;
            s1_luma_ff    <= luma;
            s1_addr_ff    <= col_cur;
            fwd_data_ff   <= write_data;
         end
      end
   end

   assign grad = grad_ff;

endmodule

// ===== hdl/sem_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// sem_sqrt_pipe
// Pipelined integer square root, one result bit per stage, carrying the
// saturation flag and pixel position alongside.
// ----------------------------------------------------------------------------
module sem_sqrt_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sem_pkg::root_in_type  in_item,
   output sem_pkg::root_out_type out_item
);
   import sem_pkg::*;

   localparam int TrialW = RAD_W + 2;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      pos_meta_type      meta;
   } stage_type;

   stage_type         stage_ff [ROOT_W+1];
   logic [RAD_W-1:0]  rem_next  [ROOT_W];
   logic [ROOT_W-1:0] root_next [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int Bit = ROOT_W - 1 - k;
      logic [TrialW-1:0] trial;
      logic              take;

      // (root + 2^Bit)^2 - root^2
      assign trial = ({{(TrialW-ROOT_W){1'b0}}, stage_ff[k].root} << (Bit + 1))
                     + (TrialW'(1) << (2 * Bit));
      assign take  = {2'b00, stage_ff[k].rem} >= trial;
      assign rem_next[k]  = take ? stage_ff[k].rem - trial[RAD_W-1:0] : stage_ff[k].rem;
      assign root_next[k] = take ? stage_ff[k].root | (ROOT_W'(1) << Bit)
                                 : stage_ff[k].root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ROOT_W; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         stage_ff[0].valid <= in_item.valid;
         stage_ff[0].sat   <= in_item.sat;
         stage_ff[0].rem   <= in_item.radicand;
         stage_ff[0].root  <= '0;
         stage_ff[0].meta  <= in_item.meta;
         for (int k = 0; k < ROOT_W; k++) begin
            stage_ff[k+1].valid <= stage_ff[k].valid;
            stage_ff[k+1].sat   <= stage_ff[k].sat;
            stage_ff[k+1].rem   <= rem_next[k];
            stage_ff[k+1].root  <= root_next[k];
            stage_ff[k+1].meta  <= stage_ff[k].meta;
         end
      end
   end

   assign out_item.valid = stage_ff[ROOT_W].valid;
   assign out_item.sat   = stage_ff[ROOT_W].sat;
   assign out_item.root  = stage_ff[ROOT_W].root;
   assign out_item.meta  = stage_ff[ROOT_W].meta;

endmodule

// ===== hdl/sobel_edge_magnitude_core.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// Streaming 3x3 Sobel gradient magnitude over 8-bit luma pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order whenever the result side keeps
// up; the rate is set by the line store, a MAX_WIDTH x 16-bit RAM that is
// read and written once per pixel (a pixel that hits the entry being written
// in the same cycle is forwarded). A result passes the window, gradient,
// square, square-root and output registers after its last window pixel
// is transferred. The pipeline holds as a whole while a result waits on
// rsp_tready, and req_tready follows that. Border pixels give no result;
// rsp_tlast marks the result of the last interior pixel of a frame. The
// line store is never cleared; stale reads only come in rows with no result.
// Write frame_width and frame_height only while the block is idle.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] luma
   input  logic                            req_tuser,   // frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [7:0] edge_strength,
                                                        // [19:8] out_row,
                                                        // [31:20] out_col
   output logic                            rsp_tlast,   // frame_done
   input  logic                            csr_we,
   input  logic [sem_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sem_pkg::CFG_W-1:0]       csr_wdata
);
   import sem_pkg::*;

   localparam int WidthW     = $clog2(MAX_WIDTH) + 1;
   localparam int ResetWidth = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   logic [WidthW-1:0] frame_width_ff;
   logic [CFG_W-1:0]  frame_height_ff;
   logic              advance;

   grad_item_type     grad;
   logic signed [SQ_W:0] sq_gx_ext, sq_gy_ext;
   logic              sq_valid_ff;
   logic [SQ_W-1:0]   sq_x_ff, sq_y_ff;
   pos_meta_type      sq_meta_ff;
   logic [SQ_W:0]     sq_sum;
   root_in_type       root_in;
   root_out_type      root_out;

   logic              rsp_valid_ff;
   logic [ROOT_W-1:0] rsp_edge_ff;
   pos_meta_type      rsp_meta_ff;

   // registers hold the clamped frame size
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WidthW'(ResetWidth);
         frame_height_ff <= CFG_W'(RESET_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH: begin
               if (csr_wdata < CFG_W'(MIN_DIM)) begin
                  frame_width_ff <= WidthW'(MIN_DIM);
               end else if ({19'd0, csr_wdata} > 32'(MAX_WIDTH)) begin
                  frame_width_ff <= WidthW'(MAX_WIDTH);
               end else begin
                  frame_width_ff <= WidthW'(csr_wdata);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_wdata < CFG_W'(MIN_DIM)) begin
                  frame_height_ff <= CFG_W'(MIN_DIM);
               end else if (csr_wdata > CFG_W'(MAX_HEIGHT)) begin
                  frame_height_ff <= CFG_W'(MAX_HEIGHT);
               end else begin
                  frame_height_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // whole pipeline moves while the output register is free or drains
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   sem_window_stage #(
      .MAX_WIDTH    (MAX_WIDTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .luma         (req_tdata),
      .frame_start  (req_tuser),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .grad         (grad)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= grad.valid;
      end
   end

   // widen before squaring so the product keeps all its bits
   assign sq_gx_ext = {{(SQ_W+1-GRAD_W){grad.gx[GRAD_W-1]}}, grad.gx};
   assign sq_gy_ext = {{(SQ_W+1-GRAD_W){grad.gy[GRAD_W-1]}}, grad.gy};

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_x_ff    <= SQ_W'(sq_gx_ext * sq_gx_ext);
         sq_y_ff    <= SQ_W'(sq_gy_ext * sq_gy_ext);
         sq_meta_ff <= grad.meta;
      end
   end

   always_comb begin
      sq_sum           = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      root_in.valid    = sq_valid_ff;
      root_in.sat      = |sq_sum[SQ_W:RAD_W];
      root_in.radicand = sq_sum[RAD_W-1:0];
      root_in.meta     = sq_meta_ff;
   end

   sem_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_item  (root_in),
      .out_item (root_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= root_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_edge_ff <= root_out.sat ? SAT_LIMIT : root_out.root;
         rsp_meta_ff <= root_out.meta;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_meta_ff.col, rsp_meta_ff.row, rsp_edge_ff};
   assign rsp_tlast  = rsp_meta_ff.done;

endmodule
